// ===== design/jic_pkg.sv =====
// Shared types and constants for the joystick input conditioner.
// Used by jic_debounce, jic_axis_scale and joystick_input_conditioner.
// No dependencies.
package jic_pkg;

  localparam int ButtonCount = 3;
  localparam int AxisWidth   = 10;
  localparam int ValueWidth  = 16;
  localparam int TimeWidth   = 32;
  localparam int DebWidth    = 16;
  localparam int CfgIdxWidth = 1;
  localparam int CfgDataWidth = 16;

  localparam logic [DebWidth-1:0]  DebounceReset = DebWidth'(50);
  localparam logic [AxisWidth-1:0] DeadzoneReset = AxisWidth'(20);

  typedef enum logic {
    KIND_SAMPLE    = 1'b0,
    KIND_HOST_READ = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DEBOUNCE_MS = 1'b0,
    CFG_DEADZONE    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                         deflected;
    logic signed [ValueWidth-1:0] value;
  } axis_res_t;

endpackage

// ===== design/jic_axis_scale.sv =====
// Deadzone check and scaling of one axis reading: raw*65535/1023 - 32768.
// Depends on jic_pkg.
module jic_axis_scale (
  input  logic [jic_pkg::AxisWidth-1:0] raw_i,
  input  logic [jic_pkg::AxisWidth-1:0] deadzone_i,
  output jic_pkg::axis_res_t            res_o
);

  // raw*65535/1023 equals 64*raw + (63*raw)/1023; the small quotient comes
  // from a reciprocal estimate with one correction step.
  logic [15:0] frac;
  logic [25:0] est;
  logic [5:0]  q0;
  logic [15:0] rem;
  logic [5:0]  q;
  logic [15:0] scaled;

  always_comb begin
    frac   = (16'(raw_i) << 6) - 16'(raw_i);
    est    = 26'(frac) + (26'(frac) << 10);
    q0     = est[25:20];
    rem    = frac - ((16'(q0) << 10) - 16'(q0));
    q      = (rem >= 16'd1023) ? q0 + 6'd1 : q0;
    scaled = {raw_i, q};
    res_o.deflected = (raw_i > deadzone_i);
    res_o.value     = res_o.deflected ? $signed(scaled ^ 16'h8000) : '0;
  end

endmodule

// ===== design/jic_debounce.sv =====
// Button debounce state: last raw level, change time and stable level per button.
// Depends on jic_pkg.
module jic_debounce (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              sample_en_i,
  input  logic [jic_pkg::ButtonCount-1:0]   raw_i,
  input  logic [jic_pkg::TimeWidth-1:0]     now_i,
  input  logic [jic_pkg::DebWidth-1:0]      debounce_ms_i,
  output logic [jic_pkg::ButtonCount-1:0]   stable_d_o
);

  logic [jic_pkg::ButtonCount-1:0] last_q, last_d;
  logic [jic_pkg::ButtonCount-1:0] stable_q, stable_d;
  logic [jic_pkg::TimeWidth-1:0]   change_q [jic_pkg::ButtonCount];
  logic [jic_pkg::TimeWidth-1:0]   change_d [jic_pkg::ButtonCount];
  logic [jic_pkg::TimeWidth-1:0]   elapsed;

  always_comb begin
    last_d   = last_q;
    stable_d = stable_q;
    elapsed  = '0;
    for (int i = 0; i < jic_pkg::ButtonCount; i++) begin
      change_d[i] = change_q[i];
      if (sample_en_i) begin
        if (raw_i[i] != last_q[i]) begin
          change_d[i] = now_i;
          last_d[i]   = raw_i[i];
        end
        elapsed = now_i - change_d[i];
        if (elapsed > jic_pkg::TimeWidth'(debounce_ms_i)) begin
          stable_d[i] = raw_i[i];
        end
      end
    end
  end

  assign stable_d_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      stable_q <= '0;
      for (int i = 0; i < jic_pkg::ButtonCount; i++) begin
        change_q[i] <= '0;
      end
    end else begin
      last_q   <= last_d;
      stable_q <= stable_d;
      for (int i = 0; i < jic_pkg::ButtonCount; i++) begin
        change_q[i] <= change_d[i];
      end
    end
  end

endmodule

// ===== design/joystick_input_conditioner.sv =====
// Top level of the joystick input conditioner: input register, debounce,
// axis scaling, result register and configuration registers.
// Depends on jic_pkg, jic_debounce and jic_axis_scale.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one item per
// transaction, either a sample (kind 0) or a host status read (kind 1).
// The output channel (out_valid_o / out_stall_i) returns exactly one result
// per item: debounced buttons, three scaled axes and the interrupt flag.
// An item is held in the input register and its result is loaded into the
// output register when the item advances, which needs the output register to
// be empty or its result to be taken; the result is shown until it is taken.
// One item per cycle is sustained while the receiver does not stall;
// the rate is set by the single debounce and axis update stage.
// When the receiver stalls, the result is held and the input register keeps
// its item, after which in_stall_o is raised until the result is taken.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always taken and
// must only be issued while the block is idle.
// Reset clears the button, axis and interrupt state but not the result register,
// and loads a debounce time of 50 ms and a deadzone of 20.
module joystick_input_conditioner (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic [2:0]                           raw_buttons_i,
  input  logic [jic_pkg::AxisWidth-1:0]        raw_axis_x_i,
  input  logic [jic_pkg::AxisWidth-1:0]        raw_axis_y_i,
  input  logic [jic_pkg::AxisWidth-1:0]        raw_axis_z_i,
  input  logic [jic_pkg::TimeWidth-1:0]        now_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           button_bits_o,
  output logic signed [jic_pkg::ValueWidth-1:0] axis_x_o,
  output logic signed [jic_pkg::ValueWidth-1:0] axis_y_o,
  output logic signed [jic_pkg::ValueWidth-1:0] axis_z_o,
  output logic                                 irq_active_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [jic_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [jic_pkg::CfgDataWidth-1:0]     cfg_data_i
);

  logic [jic_pkg::DebWidth-1:0]  debounce_ms_q;
  logic [jic_pkg::AxisWidth-1:0] deadzone_q;

  logic                            in_valid_q;
  jic_pkg::kind_e                  kind_q;
  logic [jic_pkg::ButtonCount-1:0] buttons_q;
  logic [jic_pkg::AxisWidth-1:0]   raw_x_q, raw_y_q, raw_z_q;
  logic [jic_pkg::TimeWidth-1:0]   now_q;

  logic                            advance;
  logic                            in_accept;
  logic                            sample_en;
  logic [jic_pkg::ButtonCount-1:0] stable_d;
  jic_pkg::axis_res_t              res_x, res_y, res_z;
  logic signed [jic_pkg::ValueWidth-1:0] axis_x_q, axis_y_q, axis_z_q;
  logic signed [jic_pkg::ValueWidth-1:0] axis_x_d, axis_y_d, axis_z_d;
  logic                            irq_q, irq_d;
  logic                            any_deflected;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q <= jic_pkg::DebounceReset;
      deadzone_q    <= jic_pkg::DeadzoneReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (jic_pkg::cfg_idx_e'(cfg_index_i))
        jic_pkg::CFG_DEBOUNCE_MS: debounce_ms_q <= cfg_data_i[jic_pkg::DebWidth-1:0];
        jic_pkg::CFG_DEADZONE:    deadzone_q    <= cfg_data_i[jic_pkg::AxisWidth-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign sample_en  = advance && (kind_q == jic_pkg::KIND_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q    <= jic_pkg::kind_e'(kind_i);
      buttons_q <= raw_buttons_i[jic_pkg::ButtonCount-1:0];
      raw_x_q   <= raw_axis_x_i;
      raw_y_q   <= raw_axis_y_i;
      raw_z_q   <= raw_axis_z_i;
      now_q     <= now_ms_i;
    end
  end

  jic_debounce u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_en_i   (sample_en),
    .raw_i         (buttons_q),
    .now_i         (now_q),
    .debounce_ms_i (debounce_ms_q),
    .stable_d_o    (stable_d)
  );

  jic_axis_scale u_scale_x (.raw_i(raw_x_q), .deadzone_i(deadzone_q), .res_o(res_x));
  jic_axis_scale u_scale_y (.raw_i(raw_y_q), .deadzone_i(deadzone_q), .res_o(res_y));
  jic_axis_scale u_scale_z (.raw_i(raw_z_q), .deadzone_i(deadzone_q), .res_o(res_z));

  assign any_deflected = res_x.deflected || res_y.deflected || res_z.deflected;

  always_comb begin
    axis_x_d = axis_x_q;
    axis_y_d = axis_y_q;
    axis_z_d = axis_z_q;
    irq_d    = irq_q;
    if (advance) begin
      if (kind_q == jic_pkg::KIND_SAMPLE) begin
        axis_x_d = res_x.value;
        axis_y_d = res_y.value;
        axis_z_d = res_z.value;
        if (any_deflected) begin
          irq_d = 1'b1;
        end
      end else begin
        irq_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_x_q <= '0;
      axis_y_q <= '0;
      axis_z_q <= '0;
      irq_q    <= 1'b0;
    end else begin
      axis_x_q <= axis_x_d;
      axis_y_q <= axis_y_d;
      axis_z_q <= axis_z_d;
      irq_q    <= irq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      button_bits_o <= 3'(stable_d);
      axis_x_o      <= axis_x_d;
      axis_y_o      <= axis_y_d;
      axis_z_o      <= axis_z_d;
      irq_active_o  <= irq_d;
    end
  end

  // A host read always reports the interrupt as cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && kind_q == jic_pkg::KIND_HOST_READ) |=> !irq_active_o)
    else $error("host read result shows interrupt active");

  // A deflected sample raises the interrupt in its own result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_en && any_deflected) |=> (irq_active_o && irq_q))
    else $error("deflected sample did not raise interrupt");

  // The input side stalls only while a result is waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // The held axis state and the shown result agree after each load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (axis_x_o == axis_x_q && axis_y_o == axis_y_q && axis_z_o == axis_z_q))
    else $error("result axes differ from axis state");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for joystick_input_conditioner. A directed stimulus table is run first,
// then random sample and host-read traffic under several register settings.
// Depends on jic_pkg and the joystick_input_conditioner RTL.
module tb;

  localparam int          NumDirected    = 17;
  localparam int          NumSettings    = 5;
  localparam int          ItemsPerSetting = 150;
  localparam int          SettleCycles   = 6;
  localparam logic [31:0] AxisFull       = 32'd1023;
  localparam logic [31:0] AxisSpan       = 32'd65535;
  localparam logic [31:0] AxisMid        = 32'd32768;

  typedef struct packed {
    jic_pkg::kind_e                 kind;
    logic [2:0]                     buttons;
    logic [jic_pkg::AxisWidth-1:0]  ax;
    logic [jic_pkg::AxisWidth-1:0]  ay;
    logic [jic_pkg::AxisWidth-1:0]  az;
    logic [jic_pkg::TimeWidth-1:0]  now;
  } joy_item_t;

  typedef struct packed {
    logic [2:0]                            buttons;
    logic signed [jic_pkg::ValueWidth-1:0] ax;
    logic signed [jic_pkg::ValueWidth-1:0] ay;
    logic signed [jic_pkg::ValueWidth-1:0] az;
    logic                                  irq;
  } joy_report_t;

  typedef struct packed {
    joy_item_t   item;
    logic        known;
    joy_report_t report;
  } directed_row_t;

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni = 1'b0;
  logic                                   in_valid_i = 1'b0;
  logic                                   in_stall_o;
  logic                                   kind_i = 1'b0;
  logic [2:0]                             raw_buttons_i = '0;
  logic [jic_pkg::AxisWidth-1:0]          raw_axis_x_i = '0;
  logic [jic_pkg::AxisWidth-1:0]          raw_axis_y_i = '0;
  logic [jic_pkg::AxisWidth-1:0]          raw_axis_z_i = '0;
  logic [jic_pkg::TimeWidth-1:0]          now_ms_i = '0;
  logic                                   out_valid_o;
  logic                                   out_stall_i = 1'b0;
  logic [2:0]                             button_bits_o;
  logic signed [jic_pkg::ValueWidth-1:0]  axis_x_o;
  logic signed [jic_pkg::ValueWidth-1:0]  axis_y_o;
  logic signed [jic_pkg::ValueWidth-1:0]  axis_z_o;
  logic                                   irq_active_o;
  logic                                   cfg_valid_i = 1'b0;
  logic                                   cfg_ready_o;
  logic [jic_pkg::CfgIdxWidth-1:0]        cfg_index_i = '0;
  logic [jic_pkg::CfgDataWidth-1:0]       cfg_data_i = '0;

  // Shadow copy of the block's state and registers.
  logic [2:0]                             seen_level = '0;
  logic [2:0]                             settled_level = '0;
  logic [jic_pkg::TimeWidth-1:0]          edge_stamp [3] = '{default: '0};
  logic signed [jic_pkg::ValueWidth-1:0]  held_axis [3] = '{default: '0};
  logic                                   irq_pending = 1'b0;
  logic [jic_pkg::DebWidth-1:0]           debounce_limit = jic_pkg::DebounceReset;
  logic [jic_pkg::AxisWidth-1:0]          deadzone_limit = jic_pkg::DeadzoneReset;

  joy_report_t                   pending_reports [$];
  directed_row_t                 directed_rows [NumDirected];
  int unsigned                   mismatch_count = 0;
  int unsigned                   reports_checked = 0;
  int unsigned                   samples_sent = 0;
  int unsigned                   host_reads_sent = 0;
  int unsigned                   settings_used = 1;
  bit                            steady_stretch = 1'b0;

  joystick_input_conditioner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .raw_buttons_i (raw_buttons_i),
    .raw_axis_x_i  (raw_axis_x_i),
    .raw_axis_y_i  (raw_axis_y_i),
    .raw_axis_z_i  (raw_axis_z_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .button_bits_o (button_bits_o),
    .axis_x_o      (axis_x_o),
    .axis_y_o      (axis_y_o),
    .axis_z_o      (axis_z_o),
    .irq_active_o  (irq_active_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL joystick_input_conditioner");
    $finish;
  end

  function automatic logic signed [jic_pkg::ValueWidth-1:0] scale_reading(
      logic [jic_pkg::AxisWidth-1:0] raw);
    logic [31:0] scaled;
    scaled = (32'(raw) * AxisSpan) / AxisFull;
    return jic_pkg::ValueWidth'(scaled - AxisMid);
  endfunction

  function joy_report_t advance_conditioner(joy_item_t item);
    joy_report_t rep;
    logic [jic_pkg::AxisWidth-1:0] raw [3];
    raw[0] = item.ax;
    raw[1] = item.ay;
    raw[2] = item.az;
    if (item.kind == jic_pkg::KIND_SAMPLE) begin
      for (int b = 0; b < 3; b++) begin
        if (item.buttons[b] != seen_level[b]) begin
          edge_stamp[b] = item.now;
          seen_level[b] = item.buttons[b];
        end
        if (32'(item.now - edge_stamp[b]) > 32'(debounce_limit)) begin
          settled_level[b] = item.buttons[b];
        end
      end
      for (int a = 0; a < 3; a++) begin
        if (raw[a] > deadzone_limit) begin
          held_axis[a] = scale_reading(raw[a]);
          irq_pending = 1'b1;
        end else begin
          held_axis[a] = '0;
        end
      end
    end else begin
      irq_pending = 1'b0;
    end
    rep.buttons = settled_level;
    rep.ax = held_axis[0];
    rep.ay = held_axis[1];
    rep.az = held_axis[2];
    rep.irq = irq_pending;
    return rep;
  endfunction

  function automatic logic [jic_pkg::AxisWidth-1:0] pick_reading(
      logic [jic_pkg::AxisWidth-1:0] dz);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (roll < 32) return dz;
    if (roll < 44) return dz + 1'b1;
    return jic_pkg::AxisWidth'($urandom_range(0, 1023));
  endfunction

  // Drives one item and records its expected report once the transaction completes.
  task automatic send_item(joy_item_t item, logic known, joy_report_t typed);
    joy_report_t predicted;
    if (!steady_stretch && $urandom_range(0, 99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= item.kind;
    raw_buttons_i <= item.buttons;
    raw_axis_x_i <= item.ax;
    raw_axis_y_i <= item.ay;
    raw_axis_z_i <= item.az;
    now_ms_i <= item.now;
    do @(posedge clk_i); while (in_stall_o);
    predicted = advance_conditioner(item);
    pending_reports.push_back(known ? typed : predicted);
    if (item.kind == jic_pkg::KIND_SAMPLE) samples_sent++;
    else host_reads_sent++;
  endtask

  task automatic write_register(jic_pkg::cfg_idx_e idx,
                                logic [jic_pkg::CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == jic_pkg::CFG_DEBOUNCE_MS) debounce_limit = data;
    else deadzone_limit = data[jic_pkg::AxisWidth-1:0];
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !steady_stretch && ($urandom_range(0, 99) < 13);
  end

  always @(posedge clk_i) begin
    joy_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("Result arrived with no expectation waiting.");
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (button_bits_o !== want.buttons) begin
          $error("button_bits: expected %0d, actual %0d", want.buttons, button_bits_o);
          mismatch_count++;
        end
        if (axis_x_o !== want.ax) begin
          $error("axis_x: expected %0d, actual %0d", want.ax, axis_x_o);
          mismatch_count++;
        end
        if (axis_y_o !== want.ay) begin
          $error("axis_y: expected %0d, actual %0d", want.ay, axis_y_o);
          mismatch_count++;
        end
        if (axis_z_o !== want.az) begin
          $error("axis_z: expected %0d, actual %0d", want.az, axis_z_o);
          mismatch_count++;
        end
        if (irq_active_o !== want.irq) begin
          $error("irq_active: expected %0d, actual %0d", want.irq, irq_active_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [jic_pkg::DebWidth-1:0]  deb_setting [NumSettings];
    logic [jic_pkg::AxisWidth-1:0] dz_setting [NumSettings];
    logic [jic_pkg::TimeWidth-1:0] clock_ms;
    logic [2:0]                    held_buttons;
    joy_item_t                     item;
    int unsigned                   step_max;

    deb_setting = '{16'd0, 16'd65535, 16'd7, 16'd50, 16'd300};
    dz_setting = '{10'd0, 10'd1023, 10'd512, 10'd20, 10'd1000};

    directed_rows[0] = '{'{jic_pkg::KIND_HOST_READ, 3'd7, 10'd1023, 10'd1023, 10'd1023,
                           32'hFFFF_FFFF}, 1'b1, '{3'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}};
    directed_rows[1] = '{'{jic_pkg::KIND_SAMPLE, 3'd7, 10'd1023, 10'd0, 10'd20,
                           32'd100}, 1'b1, '{3'd0, 16'sd32767, 16'sd0, 16'sd0, 1'b1}};
    directed_rows[2] = '{'{jic_pkg::KIND_SAMPLE, 3'd7, 10'd21, 10'd1023, 10'd0,
                           32'd150}, 1'b0, '0};
    directed_rows[3] = '{'{jic_pkg::KIND_SAMPLE, 3'd7, 10'd0, 10'd0, 10'd1023,
                           32'd151}, 1'b1, '{3'd7, 16'sd0, 16'sd0, 16'sd32767, 1'b1}};
    directed_rows[4] = '{'{jic_pkg::KIND_HOST_READ, 3'd0, 10'd0, 10'd0, 10'd0,
                           32'd0}, 1'b1, '{3'd7, 16'sd0, 16'sd0, 16'sd32767, 1'b0}};
    directed_rows[5] = '{'{jic_pkg::KIND_SAMPLE, 3'd7, 10'd0, 10'd0, 10'd0,
                           32'd300}, 1'b1, '{3'd7, 16'sd0, 16'sd0, 16'sd0, 1'b0}};
    directed_rows[6] = '{'{jic_pkg::KIND_SAMPLE, 3'd2, 10'd512, 10'd20, 10'd21,
                           32'd320}, 1'b0, '0};
    directed_rows[7] = '{'{jic_pkg::KIND_SAMPLE, 3'd2, 10'd1022, 10'd1, 10'd1000,
                           32'd371}, 1'b0, '0};
    directed_rows[8] = '{'{jic_pkg::KIND_HOST_READ, 3'd5, 10'd700, 10'd700, 10'd700,
                           32'd5}, 1'b0, '0};
    directed_rows[9] = '{'{jic_pkg::KIND_SAMPLE, 3'd5, 10'd0, 10'd0, 10'd0,
                           32'hFFFF_FFF0}, 1'b0, '0};
    directed_rows[10] = '{'{jic_pkg::KIND_SAMPLE, 3'd5, 10'd0, 10'd0, 10'd0,
                            32'h0000_0023}, 1'b1, '{3'd5, 16'sd0, 16'sd0, 16'sd0, 1'b0}};
    directed_rows[11] = '{'{jic_pkg::KIND_SAMPLE, 3'd5, 10'd1023, 10'd1023, 10'd1023,
                            32'h0000_0024}, 1'b1,
                          '{3'd5, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1}};
    directed_rows[12] = '{'{jic_pkg::KIND_SAMPLE, 3'd5, 10'd0, 10'd0, 10'd0,
                            32'h0000_0025}, 1'b1, '{3'd5, 16'sd0, 16'sd0, 16'sd0, 1'b1}};
    directed_rows[13] = '{'{jic_pkg::KIND_SAMPLE, 3'd0, 10'd341, 10'd682, 10'd300,
                            32'h7FFF_FFFF}, 1'b0, '0};
    directed_rows[14] = '{'{jic_pkg::KIND_SAMPLE, 3'd0, 10'd0, 10'd0, 10'd0,
                            32'h8000_0040}, 1'b0, '0};
    directed_rows[15] = '{'{jic_pkg::KIND_HOST_READ, 3'd2, 10'd5, 10'd5, 10'd5,
                            32'h8000_0040}, 1'b0, '0};
    directed_rows[16] = '{'{jic_pkg::KIND_SAMPLE, 3'd7, 10'd20, 10'd21, 10'd20,
                            32'h8000_0041}, 1'b0, '0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirected; r++) begin
      send_item(directed_rows[r].item, directed_rows[r].known, directed_rows[r].report);
    end

    clock_ms = 32'h8000_0100;
    held_buttons = 3'd0;
    for (int s = 0; s < NumSettings; s++) begin
      // Registers change only once the block has drained.
      in_valid_i <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
      write_register(jic_pkg::CFG_DEBOUNCE_MS, deb_setting[s]);
      write_register(jic_pkg::CFG_DEADZONE, jic_pkg::CfgDataWidth'(dz_setting[s]));
      cfg_valid_i <= 1'b0;
      settings_used++;
      steady_stretch = (s == 3);
      if (s == 2) clock_ms = 32'hFFFF_FF00;
      step_max = (debounce_limit < 200) ? 32'(debounce_limit) / 4 + 3 : 60;

      for (int n = 0; n < ItemsPerSetting; n++) begin
        if ($urandom_range(0, 99) < 20) held_buttons ^= 3'($urandom_range(1, 7));
        if ($urandom_range(0, 99) < 4) clock_ms += $urandom_range(0, 70000);
        else clock_ms += $urandom_range(0, step_max);
        item.kind = ($urandom_range(0, 99) < 15) ? jic_pkg::KIND_HOST_READ
                                                 : jic_pkg::KIND_SAMPLE;
        item.buttons = held_buttons;
        item.ax = pick_reading(deadzone_limit);
        item.ay = pick_reading(deadzone_limit);
        item.az = pick_reading(deadzone_limit);
        item.now = clock_ms;
        if ($urandom_range(0, 99) < 5) begin
          item.buttons = 3'($urandom_range(0, 7));
          item.now = $urandom;
        end
        send_item(item, 1'b0, '0);
      end
    end
    steady_stretch = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d samples and %0d host reads under %0d register settings.",
             samples_sent, host_reads_sent, settings_used);
    $display("Checked %0d results, %0d field mismatches.", reports_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS joystick_input_conditioner");
    end else begin
      $display("FAIL joystick_input_conditioner");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/jic_pkg.sv
design/jic_axis_scale.sv
design/jic_debounce.sv
design/joystick_input_conditioner.sv
tb/tb.sv
